// ===== sv/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COORD_BITS  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int FIELD_W     = 32;
    localparam int IN_W        = 9 * FIELD_W;
    localparam int OUT_W       = 12 * FIELD_W;

    // stage counts
    localparam int PRE_LAT   = 5;   // abs, msb, shift, square, sum
    localparam int SQ_LAT    = 32;  // one root bit per stage
    localparam int DIV_LAT   = 31;  // one quotient bit per stage
    localparam int UNIT_LAT  = PRE_LAT + SQ_LAT + DIV_LAT + 1;
    localparam int TOTAL_LAT = 2 * UNIT_LAT + 8;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [63:0] wide_t;
    typedef logic [31:0]        len_t;
    typedef logic [30:0]        mag_t;

    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
    } vec3_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec3_t;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } sgn_t;

endpackage

// ===== sv/lav_isqrt.sv =====
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lav_isqrt (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   sum,
    output lav_pkg::len_t root
);

    logic [63:0] x_reg  [0:lav_pkg::SQ_LAT-1];
    logic [63:0] x_next [0:lav_pkg::SQ_LAT-1];
    logic [63:0] r_reg  [0:lav_pkg::SQ_LAT-1];
    logic [63:0] r_next [0:lav_pkg::SQ_LAT-1];

    always_comb
    begin
        logic [63:0] xi;
        logic [63:0] ri;
        logic [63:0] bitv;
        logic [64:0] trial;
        for (int k = 0; k < lav_pkg::SQ_LAT; k++)
        begin
            if (k == 0)
            begin
                xi = sum;
                ri = '0;
            end
            else
            begin
                xi = x_reg[k-1];
                ri = r_reg[k-1];
            end
            bitv  = 64'd1 << (2 * (lav_pkg::SQ_LAT - 1 - k));
            trial = {1'b0, ri} + {1'b0, bitv};
            if ({1'b0, xi} >= trial)
            begin
                x_next[k] = xi - trial[63:0];
                r_next[k] = (ri >> 1) + bitv;
            end
            else
            begin
                x_next[k] = xi;
                r_next[k] = ri >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < lav_pkg::SQ_LAT; k++)
            begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[lav_pkg::SQ_LAT-1][31:0];

endmodule

// ===== sv/lav_div.sv =====
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider: (mag * 2^30) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_div (
    input  logic          clk,
    input  logic          en,
    input  lav_pkg::mag_t mag,
    input  lav_pkg::len_t len,
    output lav_pkg::mag_t quo
);

    localparam int N = lav_pkg::DIV_LAT;

    logic [31:0]  rem_reg  [0:N-1];
    logic [31:0]  rem_next [0:N-1];
    logic [N-1:0] q_reg    [0:N-1];
    logic [N-1:0] q_next   [0:N-1];
    logic [31:0]  d_reg    [0:N-1];
    logic [31:0]  d_next   [0:N-1];

    always_comb
    begin
        logic [31:0]  rem;
        logic         inb;
        logic [N-1:0] q;
        logic [31:0]  d;
        logic [32:0]  trial;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                // upper dividend bits (mag >> 1) are already below len
                rem = {2'b00, mag[30:1]};
                inb = mag[0];
                q   = '0;
                d   = len;
            end
            else
            begin
                rem = rem_reg[k-1];
                inb = 1'b0;
                q   = q_reg[k-1];
                d   = d_reg[k-1];
            end
            trial = {rem, inb};
            if (trial >= {1'b0, d})
            begin
                rem_next[k] = 32'(trial - {1'b0, d});
                q_next[k]   = {q[N-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[31:0];
                q_next[k]   = {q[N-2:0], 1'b0};
            end
            d_next[k] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_next[k];
            end
        end
    end

    assign quo = q_reg[N-1];

endmodule

// ===== sv/lav_unit3.sv =====
// ----------------------------------------------------------------------------
// lav_unit3
// Pipelined 3-vector normalizer: block scale, sum of squares, root, divide.
// ----------------------------------------------------------------------------
module lav_unit3 (
    input  logic            clk,
    input  logic            en,
    input  lav_pkg::wvec3_t vec_in,
    output lav_pkg::vec3_t  vec_out
);

    localparam int PRE = lav_pkg::PRE_LAT;
    localparam int SQ  = lav_pkg::SQ_LAT;
    localparam int SD  = lav_pkg::SQ_LAT + lav_pkg::DIV_LAT;

    typedef logic [2:0][30:0] mag3_t;

    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    logic [63:0]   comp [0:2];
    logic [63:0]   orv;
    logic [5:0]    pmsb;
    logic          zero_in;
    logic [2:0]    neg_in;

    logic [63:0]   mag1_reg [0:2];
    logic [63:0]   mag2_reg [0:2];
    logic          shl2_reg;
    logic [5:0]    amt2_reg;
    mag3_t         mag3_reg;
    logic [61:0]   sq4_reg  [0:2];
    mag3_t         mag4_reg;
    logic [63:0]   sum5_reg;
    mag3_t         mag5_reg;
    lav_pkg::sgn_t sgn_reg  [0:PRE-1];
    mag3_t         mag_dly_reg [0:SQ-1];
    lav_pkg::sgn_t sgn_dly_reg [0:SD-1];
    lav_pkg::len_t root;
    lav_pkg::mag_t quo [0:2];
    lav_pkg::fix_t out_reg [0:2];

    assign comp[0] = vec_in.x;
    assign comp[1] = vec_in.y;
    assign comp[2] = vec_in.z;

    assign zero_in = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
    assign neg_in  = {comp[2][63], comp[1][63], comp[0][63]};
    assign orv     = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
    assign pmsb    = msb_pos(orv);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= comp[i][63] ? (64'd0 - comp[i]) : comp[i];
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= shl2_reg ? 31'(mag2_reg[i] << amt2_reg)
                                        : 31'(mag2_reg[i] >> amt2_reg);
                sq4_reg[i]  <= mag3_reg[i] * mag3_reg[i];
            end
            // largest magnitude lands in [2^30, 2^31)
            shl2_reg <= (pmsb < 6'd30);
            amt2_reg <= (pmsb < 6'd30) ? (6'd30 - pmsb) : (pmsb - 6'd30);
            mag4_reg <= mag3_reg;
            sum5_reg <= 64'(sq4_reg[0]) + 64'(sq4_reg[1]) + 64'(sq4_reg[2]);
            mag5_reg <= mag4_reg;

            sgn_reg[0] <= '{zero: zero_in, neg: neg_in};
            for (int k = 1; k < PRE; k++)
            begin
                sgn_reg[k] <= sgn_reg[k-1];
            end

            mag_dly_reg[0] <= mag5_reg;
            for (int k = 1; k < SQ; k++)
            begin
                mag_dly_reg[k] <= mag_dly_reg[k-1];
            end

            sgn_dly_reg[0] <= sgn_reg[PRE-1];
            for (int k = 1; k < SD; k++)
            begin
                sgn_dly_reg[k] <= sgn_dly_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                if (sgn_dly_reg[SD-1].zero)
                begin
                    out_reg[i] <= '0;
                end
                else if (sgn_dly_reg[SD-1].neg[i])
                begin
                    out_reg[i] <= 32'sd0 - $signed({1'b0, quo[i]});
                end
                else
                begin
                    out_reg[i] <= $signed({1'b0, quo[i]});
                end
            end
        end
    end

    lav_isqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .sum  (sum5_reg),
        .root (root)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        lav_div u_div (
            .clk (clk),
            .en  (en),
            .mag (mag_dly_reg[SQ-1][g]),
            .len (root),
            .quo (quo[g])
        );
    end

    assign vec_out.x = out_reg[0];
    assign vec_out.y = out_reg[1];
    assign vec_out.z = out_reg[2];

endmodule

// ===== sv/look_at_view_matrix.sv =====
// Throughput: one camera set per cycle; the whole pipe freezes only while a
// finished result waits on the output.
// Depth comes from the two normalizers: 32 root stages plus 31 divide stages.
// Reset (rst_n, async low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Camera basis u, v, n in Q2.30 and view translations in Q16.16.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z,
    // up_hint_x, up_hint_y, up_hint_z (32 bits each, low first)
    input  logic [lav_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // right_x/y/z, true_up_x/y/z, back_x/y/z,
    // offset_right, offset_up, offset_back (32 bits each, low first)
    output logic [lav_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int UL   = lav_pkg::UNIT_LAT;
    localparam int LAST = lav_pkg::TOTAL_LAT - 1;
    localparam int EYE_DLY = 2 * UL + 2;

    localparam logic signed [35:0] OFF_HI =
        (36'sd1 <<< (lav_pkg::COORD_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] OFF_LO = -OFF_HI - 36'sd1;

    // sign-extend a field from its low COORD_BITS bits
    function automatic lav_pkg::fix_t sext(input logic [31:0] f);
        logic signed [lav_pkg::COORD_BITS-1:0] t;
        t = f[lav_pkg::COORD_BITS-1:0];
        return lav_pkg::fix_t'(t);
    endfunction

    // round Q4.60 to Q2.30, clamp to [-1, 1]
    function automatic lav_pkg::fix_t round_clamp(input lav_pkg::wide_t d);
        logic signed [64:0] t;
        logic signed [34:0] s;
        t = {d[63], d} + 65'sd536870912;
        s = t[64:30];
        if (s > 35'sd1073741824)
        begin
            return 32'sd1073741824;
        end
        if (s < -35'sd1073741824)
        begin
            return -32'sd1073741824;
        end
        return s[31:0];
    endfunction

    // negate, round Q.46 down to Q16.16, saturate
    function automatic lav_pkg::fix_t round_off(input lav_pkg::wide_t d);
        logic signed [65:0] t;
        logic signed [35:0] s;
        t = 66'sd536870912 - {{2{d[63]}}, d};
        s = t[65:30];
        if (s > OFF_HI)
        begin
            return OFF_HI[31:0];
        end
        if (s < OFF_LO)
        begin
            return OFF_LO[31:0];
        end
        return s[31:0];
    endfunction

    logic                en;
    logic [LAST:0]       vld_reg;

    // stage 0: inputs and raw back axis
    lav_pkg::vec3_t      eye_reg;
    lav_pkg::vec3_t      up_reg;
    lav_pkg::wvec3_t     nraw_reg;
    lav_pkg::vec3_t      n_unit;

    // alignment lines
    lav_pkg::vec3_t      up_dly_reg  [0:UL-1];
    lav_pkg::vec3_t      eye_dly_reg [0:EYE_DLY-1];
    lav_pkg::vec3_t      n_dly_reg   [0:UL-1];

    // up cross n
    lav_pkg::wvec3_t     pa_reg;
    lav_pkg::wvec3_t     pb_reg;
    lav_pkg::vec3_t      n2_reg;
    lav_pkg::wvec3_t     uraw_reg;
    lav_pkg::vec3_t      n3_reg;
    lav_pkg::vec3_t      u_unit;

    // back end: true up and offsets
    lav_pkg::wvec3_t     va_reg;
    lav_pkg::wvec3_t     vb_reg;
    lav_pkg::wvec3_t     eu_reg;
    lav_pkg::wvec3_t     en_reg;
    lav_pkg::vec3_t      eye1_reg, u1_reg, n1_reg;
    lav_pkg::vec3_t      v2_reg;
    lav_pkg::wide_t      du2_reg, dn2_reg;
    lav_pkg::vec3_t      eye2_reg, u2_reg, n2b_reg;
    lav_pkg::wvec3_t     ev3_reg;
    lav_pkg::fix_t       offr3_reg, offb3_reg;
    lav_pkg::vec3_t      u3_reg, v3_reg, n3b_reg;
    lav_pkg::wide_t      dv4_reg;
    lav_pkg::fix_t       offr4_reg, offb4_reg;
    lav_pkg::vec3_t      u4_reg, v4_reg, n4_reg;
    lav_pkg::vec3_t      u5_reg, v5_reg, n5_reg;
    lav_pkg::fix_t       offr5_reg, offu5_reg, offb5_reg;

    // the pipe advances unless a finished result is held
    assign en            = !vld_reg[LAST] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0
            eye_reg.x  <= sext(s_axis_tdata[31:0]);
            eye_reg.y  <= sext(s_axis_tdata[63:32]);
            eye_reg.z  <= sext(s_axis_tdata[95:64]);
            up_reg.x   <= sext(s_axis_tdata[223:192]);
            up_reg.y   <= sext(s_axis_tdata[255:224]);
            up_reg.z   <= sext(s_axis_tdata[287:256]);
            nraw_reg.x <= lav_pkg::wide_t'(sext(s_axis_tdata[31:0]))
                        - lav_pkg::wide_t'(sext(s_axis_tdata[127:96]));
            nraw_reg.y <= lav_pkg::wide_t'(sext(s_axis_tdata[63:32]))
                        - lav_pkg::wide_t'(sext(s_axis_tdata[159:128]));
            nraw_reg.z <= lav_pkg::wide_t'(sext(s_axis_tdata[95:64]))
                        - lav_pkg::wide_t'(sext(s_axis_tdata[191:160]));

            up_dly_reg[0]  <= up_reg;
            eye_dly_reg[0] <= eye_reg;
            n_dly_reg[0]   <= n3_reg;
            for (int k = 1; k < UL; k++)
            begin
                up_dly_reg[k] <= up_dly_reg[k-1];
                n_dly_reg[k]  <= n_dly_reg[k-1];
            end
            for (int k = 1; k < EYE_DLY; k++)
            begin
                eye_dly_reg[k] <= eye_dly_reg[k-1];
            end

            // u_raw = up x n: products, then differences
            pa_reg.x <= up_dly_reg[UL-1].y * n_unit.z;
            pb_reg.x <= up_dly_reg[UL-1].z * n_unit.y;
            pa_reg.y <= up_dly_reg[UL-1].z * n_unit.x;
            pb_reg.y <= up_dly_reg[UL-1].x * n_unit.z;
            pa_reg.z <= up_dly_reg[UL-1].x * n_unit.y;
            pb_reg.z <= up_dly_reg[UL-1].y * n_unit.x;
            n2_reg   <= n_unit;
            uraw_reg.x <= pa_reg.x - pb_reg.x;
            uraw_reg.y <= pa_reg.y - pb_reg.y;
            uraw_reg.z <= pa_reg.z - pb_reg.z;
            n3_reg   <= n2_reg;

            // P1: v = n x u products, eye.u and eye.n products
            va_reg.x <= n_dly_reg[UL-1].y * u_unit.z;
            vb_reg.x <= n_dly_reg[UL-1].z * u_unit.y;
            va_reg.y <= n_dly_reg[UL-1].z * u_unit.x;
            vb_reg.y <= n_dly_reg[UL-1].x * u_unit.z;
            va_reg.z <= n_dly_reg[UL-1].x * u_unit.y;
            vb_reg.z <= n_dly_reg[UL-1].y * u_unit.x;
            eu_reg.x <= eye_dly_reg[EYE_DLY-1].x * u_unit.x;
            eu_reg.y <= eye_dly_reg[EYE_DLY-1].y * u_unit.y;
            eu_reg.z <= eye_dly_reg[EYE_DLY-1].z * u_unit.z;
            en_reg.x <= eye_dly_reg[EYE_DLY-1].x * n_dly_reg[UL-1].x;
            en_reg.y <= eye_dly_reg[EYE_DLY-1].y * n_dly_reg[UL-1].y;
            en_reg.z <= eye_dly_reg[EYE_DLY-1].z * n_dly_reg[UL-1].z;
            eye1_reg <= eye_dly_reg[EYE_DLY-1];
            u1_reg   <= u_unit;
            n1_reg   <= n_dly_reg[UL-1];

            // P2: true up rounded, dot sums
            v2_reg.x <= round_clamp(va_reg.x - vb_reg.x);
            v2_reg.y <= round_clamp(va_reg.y - vb_reg.y);
            v2_reg.z <= round_clamp(va_reg.z - vb_reg.z);
            du2_reg  <= eu_reg.x + eu_reg.y + eu_reg.z;
            dn2_reg  <= en_reg.x + en_reg.y + en_reg.z;
            eye2_reg <= eye1_reg;
            u2_reg   <= u1_reg;
            n2b_reg  <= n1_reg;

            // P3: eye.v products, right and back offsets
            ev3_reg.x <= eye2_reg.x * v2_reg.x;
            ev3_reg.y <= eye2_reg.y * v2_reg.y;
            ev3_reg.z <= eye2_reg.z * v2_reg.z;
            offr3_reg <= round_off(du2_reg);
            offb3_reg <= round_off(dn2_reg);
            u3_reg    <= u2_reg;
            v3_reg    <= v2_reg;
            n3b_reg   <= n2b_reg;

            // P4: eye.v sum
            dv4_reg   <= ev3_reg.x + ev3_reg.y + ev3_reg.z;
            offr4_reg <= offr3_reg;
            offb4_reg <= offb3_reg;
            u4_reg    <= u3_reg;
            v4_reg    <= v3_reg;
            n4_reg    <= n3b_reg;

            // P5: output register
            offu5_reg <= round_off(dv4_reg);
            offr5_reg <= offr4_reg;
            offb5_reg <= offb4_reg;
            u5_reg    <= u4_reg;
            v5_reg    <= v4_reg;
            n5_reg    <= n4_reg;
        end
    end

    lav_unit3 u_norm_back (
        .clk     (clk),
        .en      (en),
        .vec_in  (nraw_reg),
        .vec_out (n_unit)
    );

    lav_unit3 u_norm_right (
        .clk     (clk),
        .en      (en),
        .vec_in  (uraw_reg),
        .vec_out (u_unit)
    );

    assign m_axis_tdata = {offb5_reg, offu5_reg, offr5_reg,
                           n5_reg.z, n5_reg.y, n5_reg.x,
                           v5_reg.z, v5_reg.y, v5_reg.x,
                           u5_reg.z, u5_reg.y, u5_reg.x};

`ifndef ASSERT_OFF
    a_up_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            v5_reg.x <= 32'sd1073741824 && v5_reg.x >= -32'sd1073741824 &&
            v5_reg.y <= 32'sd1073741824 && v5_reg.y >= -32'sd1073741824 &&
            v5_reg.z <= 32'sd1073741824 && v5_reg.z >= -32'sd1073741824)
        else $error("true up axis out of range");

    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && n5_reg == '0 |-> offb5_reg == '0 && u5_reg == '0)
        else $error("zero back axis with nonzero right axis or offset");

    a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && u5_reg == '0 |->
            v5_reg == '0 && offr5_reg == '0 && offu5_reg == '0)
        else $error("zero right axis with nonzero true up or offsets");
`endif

endmodule
